// ===== sv/tiob_pkg.sv =====
package tiob_pkg;

  localparam int TICKS_DEF      = 4096;
  localparam int LEVEL_BITS_DEF = 48;

  localparam int OPCODE_W   = 2;
  localparam int TICK_W     = 12;
  localparam int QTY_W      = 32;
  localparam int BEST_W     = 13;
  localparam int OUT_LVL_W  = 48;
  localparam int MID_W      = 14;
  localparam int STATUS_W   = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_BID    = 2'd0,
    OP_ADD_ASK    = 2'd1,
    OP_REDUCE_BID = 2'd2,
    OP_REDUCE_ASK = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CLAMPED   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_SCHK,
    S_DONE
  } fsm_t;

endpackage

// ===== sv/tiob_ram.sv =====
module tiob_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tick_indexed_order_book.sv =====
// Flow: each input word is read from its side's level memory, then updated, then
// loaded into the result word; a reduce that empties the best level adds a scan
// that checks one level at a time (one memory read each) until it finds a non-empty
// level or runs off the end of its side.
// A new word is taken only once the result word of the last one has been loaded.
// Reset: best prices return to empty and a clearing pass writes zero to all
// TICKS entries of both sides before the first word is taken.
module tick_indexed_order_book #(
  parameter int TICKS      = tiob_pkg::TICKS_DEF,
  parameter int LEVEL_BITS = tiob_pkg::LEVEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // opcode[1:0], tick[13:2], quantity[45:14], zero pad
  input  logic [tiob_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // best_bid_tick[12:0], best_ask_tick[25:13], level_quantity[73:26],
  // is_crossed[74], mid_twice[88:75], status[90:89], zero pad
  output logic [tiob_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tiob_pkg::*;

  localparam int AW = $clog2(TICKS);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  fsm_t state, state_next;

  logic [AW-1:0]          clr_addr;
  opcode_t                op_r;
  logic [AW-1:0]          tick_r;
  logic [QTY_W-1:0]       qty_r;
  logic                   in_grid_r;
  logic [LEVEL_BITS-1:0]  lvl_r;
  status_t                status_r;
  logic signed [AW:0]     bid_px;
  logic        [AW:0]     ask_px;

  logic                   bid_we, ask_we, bid_re, ask_re;
  logic [AW-1:0]          bid_waddr, ask_waddr, bid_raddr, ask_raddr;
  logic [LEVEL_BITS-1:0]  wdata, bid_rdata, ask_rdata;

  logic [LEVEL_BITS-1:0]  old_lvl, new_lvl;
  logic [LEVEL_BITS:0]    sum;
  status_t                new_status;
  logic                   need_scan;
  logic                   accept, load_out;
  logic [TICK_W-1:0]      in_tick;

  assign in_tick = s_tdata[OPCODE_W +: TICK_W];
  assign accept  = s_tvalid && s_tready;
  assign load_out = (state == S_DONE) && (!m_tvalid || m_tready);

  tiob_ram #(.WIDTH(LEVEL_BITS), .DEPTH(TICKS)) u_bid_ram (
    .clk(clk), .we(bid_we), .waddr(bid_waddr), .wdata(wdata),
    .re(bid_re), .raddr(bid_raddr), .rdata(bid_rdata)
  );

  tiob_ram #(.WIDTH(LEVEL_BITS), .DEPTH(TICKS)) u_ask_ram (
    .clk(clk), .we(ask_we), .waddr(ask_waddr), .wdata(wdata),
    .re(ask_re), .raddr(ask_raddr), .rdata(ask_rdata)
  );

  // level arithmetic on the word read at accept
  always_comb begin
    old_lvl    = op_r[0] ? ask_rdata : bid_rdata;
    sum        = {1'b0, old_lvl} + (LEVEL_BITS+1)'(qty_r);
    new_status = ST_OK;
    if (!op_r[1]) begin
      if (sum > {1'b0, LEVEL_MAX}) begin
        new_lvl    = LEVEL_MAX;
        new_status = ST_SATURATED;
      end else begin
        new_lvl = sum[LEVEL_BITS-1:0];
      end
    end else begin
      if (LEVEL_BITS'(qty_r) > old_lvl) begin
        new_lvl    = '0;
        new_status = ST_CLAMPED;
      end else begin
        new_lvl = old_lvl - LEVEL_BITS'(qty_r);
      end
    end
    case (op_r)
      OP_REDUCE_BID: need_scan = (new_lvl == '0) &&
                                 (bid_px == $signed({1'b0, tick_r}));
      OP_REDUCE_ASK: need_scan = (new_lvl == '0) && (ask_px == {1'b0, tick_r});
      default:       need_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AW'(TICKS - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_UPD;
      S_UPD: begin
        if (!in_grid_r)     state_next = S_DONE;
        else if (need_scan) state_next = S_SCAN;
        else                state_next = S_DONE;
      end
      S_SCAN: begin
        if (op_r[0] ? (ask_px == (AW+1)'(TICKS)) : (bid_px < 0))
          state_next = S_DONE;
        else
          state_next = S_SCHK;
      end
      S_SCHK: begin
        if ((op_r[0] ? ask_rdata : bid_rdata) != '0) state_next = S_DONE;
        else                                          state_next = S_SCAN;
      end
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    s_tready  = (state == S_IDLE);
    bid_we    = 1'b0;
    ask_we    = 1'b0;
    bid_re    = 1'b0;
    ask_re    = 1'b0;
    bid_waddr = tick_r;
    ask_waddr = tick_r;
    wdata     = new_lvl;
    bid_raddr = bid_px[AW-1:0];
    ask_raddr = ask_px[AW-1:0];
    case (state)
      S_CLEAR: begin
        bid_we    = 1'b1;
        ask_we    = 1'b1;
        bid_waddr = clr_addr;
        ask_waddr = clr_addr;
        wdata     = '0;
      end
      S_IDLE: begin
        bid_re    = accept;
        ask_re    = accept;
        bid_raddr = AW'(in_tick);
        ask_raddr = AW'(in_tick);
      end
      S_UPD: begin
        bid_we = in_grid_r && !op_r[0];
        ask_we = in_grid_r && op_r[0];
      end
      S_SCAN: begin
        bid_re = !op_r[0];
        ask_re = op_r[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      bid_px   <= '1;
      ask_px   <= (AW+1)'(TICKS);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == S_UPD && in_grid_r) begin
        case (op_r)
          OP_ADD_BID:
            if (qty_r != '0 && $signed({1'b0, tick_r}) > bid_px)
              bid_px <= $signed({1'b0, tick_r});
          OP_ADD_ASK:
            if (qty_r != '0 && {1'b0, tick_r} < ask_px) ask_px <= {1'b0, tick_r};
          OP_REDUCE_BID: if (need_scan) bid_px <= bid_px - (AW+1)'(1);
          OP_REDUCE_ASK: if (need_scan) ask_px <= ask_px + (AW+1)'(1);
          default: ;
        endcase
      end
      // step the cursor past an empty level
      if (state == S_SCHK && (op_r[0] ? ask_rdata : bid_rdata) == '0) begin
        if (op_r[0]) ask_px <= ask_px + (AW+1)'(1);
        else         bid_px <= bid_px - (AW+1)'(1);
      end
      if (load_out)              m_tvalid <= 1'b1;
      else if (m_tready)         m_tvalid <= 1'b0;
    end
  end

  logic signed [31:0] bb_int, ba_int, mid_int;
  assign bb_int  = 32'(bid_px);
  assign ba_int  = $signed(32'(ask_px));
  assign mid_int = bb_int + ba_int;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= opcode_t'(s_tdata[OPCODE_W-1:0]);
      tick_r    <= AW'(in_tick);
      qty_r     <= s_tdata[OPCODE_W+TICK_W +: QTY_W];
      in_grid_r <= (32'(in_tick) < 32'(TICKS));
    end
    if (state == S_UPD) begin
      lvl_r    <= in_grid_r ? new_lvl : '0;
      status_r <= in_grid_r ? new_status : ST_OK;
    end
    if (load_out) begin
      m_tdata <= {5'd0, status_r, mid_int[MID_W-1:0], (bb_int >= ba_int),
                  OUT_LVL_W'(lvl_r), ba_int[BEST_W-1:0], bb_int[BEST_W-1:0]};
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready) else $error("word taken during clearing pass");

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_UPD) else $error("accepted word not updated next cycle");

  a_bid_range: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (bb_int >= -1 && bb_int < TICKS))
    else $error("best bid out of range");

  a_ask_range: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ba_int <= TICKS) else $error("best ask out of range");

endmodule
